@@ design/brfp_pkg.sv @@
// ----------------------------------------------------------------------------
// brfp_pkg
// Shared types and constants of the BOOTP reply frame parser: byte positions,
// status codes, the classified byte word and the option walk phases.
// ----------------------------------------------------------------------------
package brfp_pkg;

    // Frame geometry
    localparam int MAX_FRAME_BYTES = 1536;
    localparam int POS_W           = 11;
    localparam int OPT_START       = 282;
    localparam int COOKIE_START    = 278;

    // Classification queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Option tags
    localparam logic [7:0] TAG_PAD    = 8'h00;
    localparam logic [7:0] TAG_MASK   = 8'h01;
    localparam logic [7:0] TAG_ROUTER = 8'h03;
    localparam logic [7:0] TAG_END    = 8'hff;

    // Result status codes; ST_OK also means "no failure seen"
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_CLIENT = 3'd1,
        ST_BAD_OP     = 3'd2,
        ST_XID        = 3'd3,
        ST_COOKIE     = 3'd4,
        ST_TRUNC      = 3'd5
    } status_t;

    // What the back end does with a byte
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FIRST = 2'd1,
        KIND_YIP   = 2'd2,
        KIND_OPT   = 2'd3
    } kind_t;

    // Option walk phase; the unused code behaves as expect tag
    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Captured option class
    typedef enum logic [1:0] {
        TC_OTHER  = 2'd0,
        TC_MASK   = 2'd1,
        TC_ROUTER = 2'd2
    } tag_class_t;

    // One classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        kind_t      kind;
        status_t    fail;
        logic       short_frame;
    } brfp_word_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h63;
            2'd1:    v = 8'h82;
            2'd2:    v = 8'h53;
            2'd3:    v = 8'h63;
            default: v = 8'h63;
        endcase
        return v;
    endfunction

endpackage

@@ design/brfp_front.sv @@
// ----------------------------------------------------------------------------
// brfp_front
// Counts byte positions, runs the fixed header checks and tags each byte
// with what the back end must do with it.
// ----------------------------------------------------------------------------
module brfp_front
    import brfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        accept,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output brfp_word_t  word
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       mac_reg, mac_next;
    logic [31:0]      xid_reg;
    logic [7:0]       xid_byte;
    logic [1:0]       cookie_idx;

    // Expected transaction id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            xid_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        case (pos_reg[1:0])
            2'd2:    xid_byte = xid_reg[31:24];
            2'd3:    xid_byte = xid_reg[23:16];
            2'd0:    xid_byte = xid_reg[15:8];
            default: xid_byte = xid_reg[7:0];
        endcase
    end

    assign cookie_idx = 2'(pos_reg - POS_W'(COOKIE_START));

    // Classification of the current byte
    always_comb
    begin
        word.data        = frame_byte;
        word.last        = last_byte;
        word.kind        = KIND_NONE;
        word.fail        = ST_OK;
        word.short_frame = (pos_reg < POS_W'(OPT_START - 1));
        mac_next         = mac_reg;
        if (pos_reg == '0)
        begin
            word.kind = KIND_FIRST;
            mac_next  = frame_byte;
            if (frame_byte != 8'h00 && frame_byte != 8'hff)
                word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg <= POS_W'(5))
        begin
            if (frame_byte != mac_reg)
                word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(12))
        begin
            if (frame_byte != 8'h08) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(13))
        begin
            if (frame_byte != 8'h00) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(14))
        begin
            if (frame_byte[3:0] != 4'd5) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(23))
        begin
            if (frame_byte != 8'd17) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(36))
        begin
            if (frame_byte != 8'd0) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(37))
        begin
            if (frame_byte != 8'd68) word.fail = ST_NOT_CLIENT;
        end
        else if (pos_reg == POS_W'(42))
        begin
            if (frame_byte != 8'd2) word.fail = ST_BAD_OP;
        end
        else if (pos_reg == POS_W'(43))
        begin
            if (frame_byte != 8'd1) word.fail = ST_BAD_OP;
        end
        else if (pos_reg >= POS_W'(46) && pos_reg <= POS_W'(49))
        begin
            if (frame_byte != xid_byte) word.fail = ST_XID;
        end
        else if (pos_reg >= POS_W'(58) && pos_reg <= POS_W'(61))
        begin
            word.kind = KIND_YIP;
        end
        else if (pos_reg >= POS_W'(COOKIE_START) && pos_reg < POS_W'(OPT_START))
        begin
            if (frame_byte != cookie_byte(cookie_idx)) word.fail = ST_COOKIE;
        end
        else if (pos_reg >= POS_W'(OPT_START) && pos_reg < POS_W'(MAX_FRAME_BYTES))
        begin
            word.kind = KIND_OPT;
        end
    end

    // Position stops counting at the frame limit; the last byte rewinds it.
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (last_byte)
                pos_next = '0;
            else if (pos_reg < POS_W'(MAX_FRAME_BYTES))
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mac_reg <= mac_next;
        end
    end

endmodule

@@ design/brfp_queue.sv @@
// ----------------------------------------------------------------------------
// brfp_queue
// Short register queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module brfp_queue
    import brfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  brfp_word_t push_word,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output brfp_word_t head_word
);

    brfp_word_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count did not follow a lone push");

endmodule

@@ design/brfp_back.sv @@
// ----------------------------------------------------------------------------
// brfp_back
// Walks the vendor options, keeps the shadow and committed addresses and
// holds the per-frame result until it is taken.
// ----------------------------------------------------------------------------
module brfp_back
    import brfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  brfp_word_t  word,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] your_ip,
    output logic [31:0] subnet_mask,
    output logic [31:0] gateway
);

    status_t     reject_reg, reject_next, eff_reject, result;
    phase_t      phase_reg, phase_next;
    tag_class_t  tag_reg, tag_next;
    logic [7:0]  remain_reg, remain_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ended_reg, ended_next;
    logic [31:0] sh_ip_reg, sh_ip_next;
    logic [31:0] sh_mask_reg, sh_mask_next;
    logic [31:0] sh_gw_reg, sh_gw_next;
    logic [31:0] c_ip_reg, c_mask_reg, c_gw_reg;
    status_t     status_reg;
    logic        out_valid_reg, out_valid_next;
    logic        commit;
    logic [7:0]  b;
    logic [7:0]  remain_dec;

    assign b          = word.data;
    assign remain_dec = remain_reg - 8'd1;

    // A frame's last word waits until the result register is free.
    assign pop = word_valid && (!word.last || !out_valid_reg || out_ready);

    assign eff_reject = (reject_reg != ST_OK) ? reject_reg : word.fail;

    always_comb
    begin
        if (eff_reject != ST_OK)
            result = eff_reject;
        else if (word.short_frame)
            result = ST_TRUNC;
        else
            result = ST_OK;
    end

    assign commit = pop && word.last && (result == ST_OK);

    // Shadow and option walk next state
    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        remain_next  = remain_reg;
        idx_next     = idx_reg;
        ended_next   = ended_reg;
        sh_ip_next   = sh_ip_reg;
        sh_mask_next = sh_mask_reg;
        sh_gw_next   = sh_gw_reg;
        case (word.kind)
            KIND_FIRST:
            begin
                phase_next   = PH_TAG;
                remain_next  = '0;
                idx_next     = '0;
                ended_next   = 1'b0;
                sh_ip_next   = '0;
                sh_mask_next = c_mask_reg;
                sh_gw_next   = c_gw_reg;
            end
            KIND_YIP:
            begin
                sh_ip_next = {sh_ip_reg[23:0], b};
            end
            KIND_OPT:
            begin
                if (!ended_reg)
                begin
                    case (phase_reg)
                        PH_LEN:
                        begin
                            remain_next = b;
                            idx_next    = '0;
                            if (tag_reg != TC_OTHER && b < 8'd4)
                                tag_next = TC_OTHER;
                            phase_next = (b == 8'd0) ? PH_TAG : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (idx_reg < 3'd4)
                            begin
                                if (tag_reg == TC_MASK)
                                    sh_mask_next = {sh_mask_reg[23:0], b};
                                else if (tag_reg == TC_ROUTER)
                                    sh_gw_next = {sh_gw_reg[23:0], b};
                                idx_next = idx_reg + 3'd1;
                            end
                            remain_next = remain_dec;
                            if (remain_dec == 8'd0)
                                phase_next = PH_TAG;
                        end
                        default:
                        begin
                            phase_next = PH_TAG;
                            if (b == TAG_END)
                            begin
                                ended_next = 1'b1;
                            end
                            else if (b != TAG_PAD)
                            begin
                                phase_next = PH_LEN;
                                if (b == TAG_MASK)
                                    tag_next = TC_MASK;
                                else if (b == TAG_ROUTER)
                                    tag_next = TC_ROUTER;
                                else
                                    tag_next = TC_OTHER;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        // End of frame rewinds the per-frame walk state.
        reject_next = eff_reject;
        if (word.last)
        begin
            reject_next = ST_OK;
            phase_next  = PH_TAG;
            remain_next = '0;
            idx_next    = '0;
            ended_next  = 1'b0;
            tag_next    = TC_OTHER;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && word.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_reg    <= ST_OK;
            phase_reg     <= PH_TAG;
            tag_reg       <= TC_OTHER;
            remain_reg    <= '0;
            idx_reg       <= '0;
            ended_reg     <= 1'b0;
            sh_ip_reg     <= '0;
            sh_mask_reg   <= '0;
            sh_gw_reg     <= '0;
            c_ip_reg      <= '0;
            c_mask_reg    <= '0;
            c_gw_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                reject_reg  <= reject_next;
                phase_reg   <= phase_next;
                tag_reg     <= tag_next;
                remain_reg  <= remain_next;
                idx_reg     <= idx_next;
                ended_reg   <= ended_next;
                sh_ip_reg   <= sh_ip_next;
                sh_mask_reg <= sh_mask_next;
                sh_gw_reg   <= sh_gw_next;
                if (word.last)
                    status_reg <= result;
            end
            if (commit)
            begin
                c_ip_reg   <= sh_ip_next;
                c_mask_reg <= sh_mask_next;
                c_gw_reg   <= sh_gw_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign your_ip     = c_ip_reg;
    assign subnet_mask = c_mask_reg;
    assign gateway     = c_gw_reg;

    a_frame_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && word.last) |=> (reject_reg == ST_OK && !ended_reg && phase_reg == PH_TAG))
        else $error("walk state not rewound after frame end");

    a_commit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && status_reg == ST_OK))
        else $error("addresses committed without an accepted result");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(c_ip_reg) && $stable(c_mask_reg))
        else $error("committed values moved under a pending result");

endmodule

@@ design/bootp_reply_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// bootp_reply_frame_parser_core
// Checks a received Ethernet frame for a BOOTP reply meant for this client
// and keeps the offered address, subnet mask and gateway.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload                             Dir
//  -------  ------------------------  ----------------------------------  ---
//  input    in_valid / in_ready       frame_byte[7:0], last_byte          in
//  result   out_valid / out_ready     status[2:0], your_ip, subnet_mask,  out
//                                     gateway (32 bits each)
//  config   cfg_wr_en                 cfg_wr_data[31:0] (transaction id)  in
//
//  The block takes one byte word per cycle while in_ready is high. A result
//  word is registered once the last byte of a frame has left the queue.
//  Reset (rst_n low) clears all counters, shadows and committed addresses.
//  A four-word queue sits between classification and the option walk, so
//  the input keeps flowing while a result waits; in_ready drops only when
//  that queue is full. A frame end held at the head of the queue behind a
//  waiting result lets three more words in before that happens.
//
// The front end counts positions, checks the fixed Ethernet, IP, UDP and
// BOOTP header fields and tags each byte with a failure code and an action.
// The back end keeps the first failure of the frame, shifts in the offered
// address, walks the vendor options after the magic cookie, and on the last
// byte of an accepted frame copies the shadow values to the committed ones.
// ----------------------------------------------------------------------------
module bootp_reply_frame_parser_core
    import brfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] your_ip,
    output logic [31:0] subnet_mask,
    output logic [31:0] gateway
);

    brfp_word_t front_word;
    brfp_word_t head_word;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    brfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .word        (front_word)
    );

    brfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    brfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (q_not_empty),
        .word        (head_word),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .your_ip     (your_ip),
        .subnet_mask (subnet_mask),
        .gateway     (gateway)
    );

endmodule

@@ test/tb_bootp_reply_frame_parser_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bootp_reply_frame_parser_core
// Feeds Ethernet frames byte by byte into the BOOTP reply parser. Each frame
// is also run through a byte-level model of the parser, and every result word
// is checked field by field against that model. Directed frames cover the
// header checks but those of bytes 13 and 36, the option walk corner cases
// and the short frame boundary. Random frames follow under random transaction
// ids, with random idle cycles on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_bootp_reply_frame_parser_core;
    import brfp_pkg::*;

    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES    = 16;
    localparam int          LONG_HOLD_CYCLES = 60;
    localparam int unsigned RANDOM_BYTES     = 450;
    localparam int          RANDOM_BATCH     = 3;
    localparam logic [31:0] COOKIE           = 32'h6382_5363;

    typedef struct {
        status_t     status;
        logic [31:0] your_ip;
        logic [31:0] subnet_mask;
        logic [31:0] gateway;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] your_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway;

    // Parser model state.
    logic [31:0] xid_cfg   = '0;
    int unsigned rx_pos    = 0;
    status_t     reject    = ST_OK;
    phase_t      opt_phase = PH_TAG;
    logic [7:0]  opt_tag   = '0;
    logic [7:0]  opt_left  = '0;
    logic [7:0]  opt_idx   = '0;
    logic        opt_done  = 1'b0;
    logic [31:0] sh_ip     = '0;
    logic [31:0] sh_mask   = '0;
    logic [31:0] sh_gw     = '0;
    logic [31:0] cm_ip     = '0;
    logic [31:0] cm_mask   = '0;
    logic [31:0] cm_gw     = '0;

    reply_t      replies_due[$];
    logic [7:0]  frame_buf[$];
    int unsigned bytes_sent     = 0;
    int unsigned mismatch_count = 0;
    logic        idle_en        = 1'b1;
    logic        hold_request   = 1'b0;

    int checked_pos [0:21] = '{0, 1, 2, 3, 4, 5, 12, 13, 14, 23, 36, 37, 42, 43,
                               46, 47, 48, 49, 278, 279, 280, 281};

    bootp_reply_frame_parser_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .your_ip     (your_ip),
        .subnet_mask (subnet_mask),
        .gateway     (gateway)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void note_reject(input status_t code);
        if (reject == ST_OK)
            reject = code;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic l);
        reply_t r;
        if (rx_pos < MAX_FRAME_BYTES) begin
            if (rx_pos == 0) begin
                opt_tag   = b;
                opt_phase = PH_TAG;
                opt_left  = '0;
                opt_idx   = '0;
                opt_done  = 1'b0;
                sh_ip     = '0;
                sh_mask   = cm_mask;
                sh_gw     = cm_gw;
                if (b != 8'h00 && b != 8'hff)
                    note_reject(ST_NOT_CLIENT);
            end else if (rx_pos <= 5) begin
                if (b != opt_tag)
                    note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 12) begin
                if (b != 8'h08) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 13) begin
                if (b != 8'h00) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 14) begin
                if (b[3:0] != 4'd5) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 23) begin
                if (b != 8'd17) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 36) begin
                if (b != 8'd0) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 37) begin
                if (b != 8'd68) note_reject(ST_NOT_CLIENT);
            end else if (rx_pos == 42) begin
                if (b != 8'd2) note_reject(ST_BAD_OP);
            end else if (rx_pos == 43) begin
                if (b != 8'd1) note_reject(ST_BAD_OP);
            end else if (rx_pos >= 46 && rx_pos <= 49) begin
                if (b != 8'(xid_cfg >> (8 * (49 - rx_pos))))
                    note_reject(ST_XID);
            end else if (rx_pos >= 58 && rx_pos <= 61) begin
                sh_ip = {sh_ip[23:0], b};
            end else if (rx_pos >= COOKIE_START && rx_pos < OPT_START) begin
                if (b != 8'(COOKIE >> (8 * (281 - rx_pos))))
                    note_reject(ST_COOKIE);
            end else if (rx_pos >= OPT_START && !opt_done) begin
                // Vendor option walk: tag, length, then data bytes.
                case (opt_phase)
                    PH_LEN: begin
                        opt_left = b;
                        opt_idx  = '0;
                        if ((opt_tag == TAG_MASK || opt_tag == TAG_ROUTER) && b < 8'd4)
                            opt_tag = TAG_PAD;
                        opt_phase = (b == 8'd0) ? PH_TAG : PH_DATA;
                    end
                    PH_DATA: begin
                        if (opt_idx < 8'd4) begin
                            if (opt_tag == TAG_MASK)
                                sh_mask = {sh_mask[23:0], b};
                            else if (opt_tag == TAG_ROUTER)
                                sh_gw = {sh_gw[23:0], b};
                        end
                        if (opt_idx < 8'd255)
                            opt_idx = opt_idx + 8'd1;
                        opt_left = opt_left - 8'd1;
                        if (opt_left == 8'd0)
                            opt_phase = PH_TAG;
                    end
                    default: begin
                        opt_phase = PH_TAG;
                        if (b == TAG_END) begin
                            opt_done = 1'b1;
                        end else if (b != TAG_PAD) begin
                            opt_tag   = b;
                            opt_phase = PH_LEN;
                        end
                    end
                endcase
            end
        end

        if (!l) begin
            if (rx_pos < MAX_FRAME_BYTES)
                rx_pos++;
        end else begin
            if (reject != ST_OK)
                r.status = reject;
            else if (rx_pos + 1 < OPT_START)
                r.status = ST_TRUNC;
            else
                r.status = ST_OK;
            if (r.status == ST_OK) begin
                cm_ip   = sh_ip;
                cm_mask = sh_mask;
                cm_gw   = sh_gw;
            end
            r.your_ip     = cm_ip;
            r.subnet_mask = cm_mask;
            r.gateway     = cm_gw;
            replies_due.push_back(r);
            rx_pos    = 0;
            reject    = ST_OK;
            opt_phase = PH_TAG;
            opt_tag   = '0;
            opt_left  = '0;
            opt_idx   = '0;
            opt_done  = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------------
    function automatic void start_reply(input logic [31:0] xid, input logic [31:0] yip,
                                        input logic [7:0] mac);
        logic [7:0] v;
        frame_buf.delete();
        for (int p = 0; p < OPT_START; p++) begin
            v = 8'($urandom);
            if (p <= 5)
                v = mac;
            else if (p == 12)
                v = 8'h08;
            else if (p == 13)
                v = 8'h00;
            else if (p == 14)
                v = {v[7:4], 4'h5};
            else if (p == 23)
                v = 8'd17;
            else if (p == 36)
                v = 8'd0;
            else if (p == 37)
                v = 8'd68;
            else if (p == 42)
                v = 8'd2;
            else if (p == 43)
                v = 8'd1;
            else if (p >= 46 && p <= 49)
                v = 8'(xid >> (8 * (49 - p)));
            else if (p >= 58 && p <= 61)
                v = 8'(yip >> (8 * (61 - p)));
            else if (p >= COOKIE_START)
                v = 8'(COOKIE >> (8 * (281 - p)));
            frame_buf.push_back(v);
        end
    endfunction

    // The first four data bytes come from lead, the rest are random.
    function automatic void add_option(input logic [7:0] tag, input logic [7:0] len,
                                       input logic [31:0] lead);
        frame_buf.push_back(tag);
        frame_buf.push_back(len);
        for (int k = 0; k < len; k++)
            frame_buf.push_back(k < 4 ? 8'(lead >> (24 - 8 * k)) : 8'($urandom));
    endfunction

    function automatic void cut_frame(input int len);
        while (frame_buf.size() > len)
            void'(frame_buf.pop_back());
    endfunction

    function automatic void add_random_options();
        int         n;
        logic [7:0] t;
        n = $urandom_range(0, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: frame_buf.push_back(TAG_PAD);
                1, 2: add_option(TAG_MASK, 8'($urandom_range(4, 6)), $urandom);
                3: add_option($urandom_range(0, 1) ? TAG_MASK : TAG_ROUTER,
                              8'($urandom_range(0, 3)), $urandom);
                4, 5: add_option(TAG_ROUTER, 8'(4 * $urandom_range(1, 2)), $urandom);
                6, 7: begin
                    t = 8'($urandom_range(4, 254));
                    add_option(t, ($urandom_range(0, 15) == 0) ? 8'($urandom_range(200, 255))
                                                               : 8'($urandom_range(0, 12)),
                               $urandom);
                end
                8: frame_buf.push_back(8'($urandom));
                default: ;
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                frame_buf.push_back(TAG_END);
                repeat ($urandom_range(0, 10))
                    frame_buf.push_back(8'($urandom));
            end
            1: frame_buf.push_back(TAG_END);
            // Cut the frame inside whatever option came last.
            2: repeat ($urandom_range(1, 3))
                if (frame_buf.size() > OPT_START)
                    void'(frame_buf.pop_back());
            default: ;
        endcase
    endfunction

    function automatic void make_noise(input int len, input logic [7:0] lead_byte);
        frame_buf.delete();
        frame_buf.push_back(lead_byte);
        while (frame_buf.size() < len)
            frame_buf.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    // Starts and ends at a rising edge. Acceptance is decided at the falling
    // edge before, where in_ready is stable.
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        if (idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        last_byte  <= l;
        @(negedge clk);
        while (in_ready !== 1'b1)
            @(negedge clk);
        predict_byte(b, l);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_word(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Stops the input and waits until every expected result word is back and
    // the block has had time to finish any trailing bytes.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_xid(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        xid_cfg = v;
    endtask

    task automatic set_idling(input logic on);
        @(negedge clk);
        idle_en = on;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_header_checks();
        write_xid(32'h0000_0000);

        // Accepted reply; bytes after the end tag that look like a mask
        // option are ignored.
        start_reply(xid_cfg, 32'hffff_ffff, 8'hff);
        add_option(TAG_MASK, 8'd4, 32'hffff_ff00);
        add_option(TAG_ROUTER, 8'd4, 32'hc0a8_0101);
        frame_buf.push_back(TAG_END);
        add_option(TAG_MASK, 8'd4, 32'h0000_0000);
        send_frame();

        // One byte short of the full cookie.
        start_reply(xid_cfg, 32'h0a00_0001, 8'hff);
        void'(frame_buf.pop_back());
        send_frame();

        make_noise(1, 8'hff);
        send_frame();
        make_noise(1, 8'h5a);
        send_frame();

        // Rejected frames end a few bytes after the failing one.
        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[3] = 8'hfe;
        cut_frame(16);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'h00);
        frame_buf[12] = 8'h86;
        cut_frame(16);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[14] = 8'h46;
        cut_frame(16);
        send_frame();

        // Only the header length nibble is checked, so version 6 gets as far
        // as the short frame check.
        start_reply(xid_cfg, 32'h0506_0708, 8'hff);
        frame_buf[14] = 8'h65;
        cut_frame(40);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[23] = 8'd6;
        cut_frame(40);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[37] = 8'd67;
        cut_frame(40);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[42] = 8'd1;
        cut_frame(50);
        send_frame();

        start_reply(xid_cfg, 32'h0102_0304, 8'hff);
        frame_buf[43] = 8'd6;
        cut_frame(50);
        send_frame();

        start_reply(xid_cfg ^ 32'h0000_0100, 32'h0102_0304, 8'hff);
        cut_frame(52);
        send_frame();

        // A bad cookie rejects the frame, and its options leave the
        // committed values alone.
        start_reply(xid_cfg, 32'hdead_beef, 8'hff);
        frame_buf[281] = 8'h64;
        add_option(TAG_MASK, 8'd4, 32'h1234_5678);
        add_option(TAG_ROUTER, 8'd4, 32'h8765_4321);
        send_frame();

        // Several failures in one short frame: the earliest one is reported.
        start_reply(xid_cfg ^ 32'h0100_0000, 32'h0102_0304, 8'hff);
        frame_buf[42] = 8'd1;
        cut_frame(60);
        send_frame();
    endtask

    task automatic test_vendor_options();
        wait_drained();
        write_xid(32'hffff_ffff);

        // Pads, a short mask that is skipped, two masks where the later one
        // wins, an empty unknown option, a router list, a short router, and
        // a mask option cut by the frame end after two data bytes.
        start_reply(xid_cfg, 32'hc0a8_0164, 8'h00);
        repeat (3) frame_buf.push_back(TAG_PAD);
        add_option(TAG_MASK, 8'd2, 32'h1122_0000);
        add_option(TAG_MASK, 8'd4, 32'hffff_0000);
        add_option(8'h35, 8'd0, 32'h0);
        add_option(TAG_MASK, 8'd5, 32'hffff_ff80);
        add_option(TAG_ROUTER, 8'd8, 32'h0a00_00fe);
        add_option(TAG_ROUTER, 8'd3, 32'h0102_0300);
        add_option(TAG_MASK, 8'd4, 32'habcd_0000);
        void'(frame_buf.pop_back());
        void'(frame_buf.pop_back());
        send_frame();
    endtask

    task automatic test_random_frames();
        int          kind;
        int          p;
        int          cut;
        logic [7:0]  mac;
        logic [7:0]  lead_byte;
        int unsigned start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            wait_drained();
            write_xid($urandom);
            set_idling($urandom_range(0, 3) != 0);
            for (int f = 0; f < RANDOM_BATCH && bytes_sent - start_bytes < RANDOM_BYTES;
                 f++) begin
                kind = $urandom_range(0, 9);
                mac  = $urandom_range(0, 1) ? 8'hff : 8'h00;
                if (kind == 9) begin
                    case ($urandom_range(0, 2))
                        0:       lead_byte = 8'h00;
                        1:       lead_byte = 8'hff;
                        default: lead_byte = 8'($urandom);
                    endcase
                    make_noise($urandom_range(1, 30), lead_byte);
                end else begin
                    start_reply(xid_cfg, $urandom, mac);
                    add_random_options();
                    if (kind == 6 || kind == 7) begin
                        repeat ($urandom_range(1, 2)) begin
                            p = checked_pos[$urandom_range(0, 21)];
                            frame_buf[p] = frame_buf[p] ^ 8'($urandom_range(1, 255));
                        end
                    end else if (kind == 8) begin
                        cut = $urandom_range(1, OPT_START - 1);
                        while (frame_buf.size() > cut)
                            void'(frame_buf.pop_back());
                    end
                end
                send_frame();
            end
        end
    endtask

    // Short frames are offered while the result side is held off, so the
    // internal queue fills and the input stalls.
    task automatic test_output_backpressure();
        wait_drained();
        @(negedge clk);
        hold_request = 1'b1;
        @(posedge clk);
        repeat (24) begin
            make_noise($urandom_range(1, 4), 8'($urandom));
            send_frame();
        end
        wait_drained();
    endtask

    // Short frames back to back with no idle cycles on either side.
    task automatic test_steady_stream();
        wait_drained();
        write_xid($urandom);
        set_idling(1'b0);
        repeat (8) begin
            make_noise($urandom_range(1, 8), $urandom_range(0, 1) ? 8'hff : 8'h00);
            send_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold on request.
    // ------------------------------------------------------------------------
    initial begin : reply_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result words are compared at the falling edge before they are taken.
    initial begin : reply_checker
        reply_t want;
        forever begin
            @(negedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1) begin
                if (replies_due.size() == 0) begin
                    $error("result word with nothing expected, status %0d", status);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (status !== 3'(want.status)) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (your_ip !== want.your_ip) begin
                        $error("your_ip: expected %08h, got %08h", want.your_ip, your_ip);
                        mismatch_count++;
                    end
                    if (subnet_mask !== want.subnet_mask) begin
                        $error("subnet_mask: expected %08h, got %08h",
                               want.subnet_mask, subnet_mask);
                        mismatch_count++;
                    end
                    if (gateway !== want.gateway) begin
                        $error("gateway: expected %08h, got %08h", want.gateway, gateway);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Ends the run when no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[bootp_reply_frame_parser_core] ERROR");
        $finish;
    end

    initial begin : main_sequence
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        frame_byte  = '0;
        last_byte   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_vendor_options();
        test_random_frames();
        test_output_backpressure();
        test_steady_stream();

        wait_drained();
        if (mismatch_count == 0)
            $display("[bootp_reply_frame_parser_core] OK");
        else
            $display("[bootp_reply_frame_parser_core] ERROR");
        $finish;
    end

endmodule
